/* design/via_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the 6522-style interface adapter
// no dependencies; imported by via_core and versatile_interface_adapter_core
package via_pkg;

    // command carried in tuser of the input channel
    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_READ  = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_LINES = 3'd3,
        CMD_PINS  = 3'd4
    } t_cmd;

    // register map
    typedef enum logic [3:0] {
        REG_ORB   = 4'h0,
        REG_ORA   = 4'h1,
        REG_DDRB  = 4'h2,
        REG_DDRA  = 4'h3,
        REG_T1CL  = 4'h4,
        REG_T1CH  = 4'h5,
        REG_T1LL  = 4'h6,
        REG_T1LH  = 4'h7,
        REG_T2CL  = 4'h8,
        REG_T2CH  = 4'h9,
        REG_SR    = 4'hA,
        REG_ACR   = 4'hB,
        REG_PCR   = 4'hC,
        REG_IFR   = 4'hD,
        REG_IER   = 4'hE,
        REG_ORA_NH = 4'hF
    } t_reg_addr;

    // timer 1 modes from aux_ctrl[7:6]
    typedef enum logic [1:0] {
        T1_STOP   = 2'd0,
        T1_RELOAD = 2'd1,
        T1_SETPB7 = 2'd2,
        T1_TOGGLE = 2'd3
    } t_t1_mode;

    // interrupt flag bit positions
    localparam int FLAG_CA2     = 0;
    localparam int FLAG_CA1     = 1;
    localparam int FLAG_SHIFT   = 2;
    localparam int FLAG_CB2     = 3;
    localparam int FLAG_CB1     = 4;
    localparam int FLAG_T2      = 5;
    localparam int FLAG_T1      = 6;
    localparam int FLAG_SUMMARY = 7;

    // aux_ctrl fields
    localparam int          ACR_T2_HOLD   = 5;
    localparam int          ACR_PB7_OUT   = 7;
    localparam logic [7:0]  ACR_SR_MASK   = 8'h1C;
    localparam logic [7:0]  ACR_SR_EXT_IN = 8'h0C;

    // periph_ctrl edge polarity bits
    localparam int PCR_CA1_RISE = 0;
    localparam int PCR_CB1_RISE = 4;

    localparam logic [2:0] SHIFT_LAST = 3'd7;

    // one decoded request
    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic       side;
        logic       line_one;
        logic       line_two;
        logic [7:0] pin_mask;
        logic       pin_level;
    } t_item;

    // one result
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
        logic [7:0] port_a_out;
        logic [7:0] port_b_out;
    } t_result;

endpackage

/* design/versatile_interface_adapter_core.sv */
`timescale 1ns / 1ps
// top level of the 6522-style interface adapter: request register, state
// core and result register; depends on via_pkg and via_core
//
//  channel   dir  tdata fields (lsb first)                         tuser
//  s_axis    in   reg_addr, write_data, side, line_one, line_two,  cmd
//                 pin_mask, pin_level (24 bits)
//  m_axis    out  read_data, irq, port_a_out, port_b_out           -
//                 (25 bits, zero padded to 32)
//
// one request per cycle sustained while m_axis_tready is high; a request is
// held in the input register and is executed by the core as it moves to
// the result register, from which its result is driven onto m_axis
// synchronous active-low reset clears all core state and both valid flags
// a stalled result holds the result register, the input register and the core
// state; s_axis_tready falls only when both stages are full and m_axis_tready
// is low
module versatile_interface_adapter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // reg_addr, write_data, side, line_one,
                                       // line_two, pin_mask, pin_level
    input  logic [2:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // read_data, irq, port_a_out, port_b_out
);
    import via_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    t_result core_result;
    logic    advance;   // request moves from input register into result register
    logic    step;      // core executes the request in the input register

    assign advance       = !r_out_valid || m_axis_tready;
    assign step          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.cmd        <= t_cmd'(s_axis_tuser);
            r_in_item.reg_addr   <= s_axis_tdata[3:0];
            r_in_item.write_data <= s_axis_tdata[11:4];
            r_in_item.side       <= s_axis_tdata[12];
            r_in_item.line_one   <= s_axis_tdata[13];
            r_in_item.line_two   <= s_axis_tdata[14];
            r_in_item.pin_mask   <= s_axis_tdata[22:15];
            r_in_item.pin_level  <= s_axis_tdata[23];
        end
    end

    via_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.port_b_out, r_out.port_a_out,
                            r_out.irq, r_out.read_data};

endmodule

/* design/via_core.sv */
`timescale 1ns / 1ps
// register file, timers, shift register and interrupt logic of the adapter
// depends on via_pkg
module via_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  via_pkg::t_item   i_item,
    output via_pkg::t_result o_result
);
    import via_pkg::*;

    logic [7:0]  r_port_a, r_port_b, r_dir_a, r_dir_b;
    logic [15:0] r_t1_count, r_t1_latch, r_t2_count, r_t2_previous;
    logic [7:0]  r_t2_low_latch, r_shift_reg;
    logic [2:0]  r_shift_count;
    logic [7:0]  r_aux_ctrl, r_periph_ctrl, r_int_flags, r_int_enable;
    logic [1:0]  r_ca_lines, r_cb_lines;

    logic [7:0]  n_port_a, n_port_b, n_dir_a, n_dir_b;
    logic [15:0] n_t1_count, n_t1_latch, n_t2_count, n_t2_previous;
    logic [7:0]  n_t2_low_latch, n_shift_reg;
    logic [2:0]  n_shift_count;
    logic [7:0]  n_aux_ctrl, n_periph_ctrl, n_int_flags, n_int_enable;
    logic [1:0]  n_ca_lines, n_cb_lines;

    logic [7:0]  read_data;
    logic        t1_zero;
    logic [15:0] t2_next;
    logic [7:0]  pin_m;
    logic        prev_one;
    logic        rise, fall;
    logic [6:0]  pending;

    always_comb begin
        n_port_a       = r_port_a;
        n_port_b       = r_port_b;
        n_dir_a        = r_dir_a;
        n_dir_b        = r_dir_b;
        n_t1_count     = r_t1_count;
        n_t1_latch     = r_t1_latch;
        n_t2_count     = r_t2_count;
        n_t2_previous  = r_t2_previous;
        n_t2_low_latch = r_t2_low_latch;
        n_shift_reg    = r_shift_reg;
        n_shift_count  = r_shift_count;
        n_aux_ctrl     = r_aux_ctrl;
        n_periph_ctrl  = r_periph_ctrl;
        n_int_flags    = r_int_flags;
        n_int_enable   = r_int_enable;
        n_ca_lines     = r_ca_lines;
        n_cb_lines     = r_cb_lines;
        read_data      = 8'h00;

        t1_zero  = (r_t1_count == 16'd1);
        t2_next  = r_aux_ctrl[ACR_T2_HOLD] ? r_t2_count : r_t2_count - 16'd1;
        pin_m    = i_item.side ? (i_item.pin_mask & ~r_dir_b)
                               : (i_item.pin_mask & ~r_dir_a);
        prev_one = i_item.side ? r_cb_lines[0] : r_ca_lines[0];
        rise     = i_item.line_one & ~prev_one;
        fall     = ~i_item.line_one & prev_one;
        pending  = 7'd0;

        unique case (i_item.cmd)
            CMD_TICK: begin
                if (r_t1_count != 16'd0) begin
                    n_t1_count = r_t1_count - 16'd1;
                end
                n_t2_count = t2_next;
                if (t1_zero) begin
                    n_int_flags[FLAG_T1] = 1'b1;
                    unique case (t_t1_mode'(r_aux_ctrl[7:6]))
                        T1_RELOAD: n_t1_count = r_t1_latch;
                        T1_SETPB7: n_port_b[7] = 1'b1;
                        T1_TOGGLE: begin
                            n_port_b[7] = ~r_port_b[7];
                            n_t1_count  = r_t1_latch;
                        end
                        default: ;
                    endcase
                end
                if (t2_next == 16'd0 && t2_next != r_t2_previous) begin
                    n_int_flags[FLAG_T2] = 1'b1;
                end
                // summary bit follows enabled pending flags
                pending = n_int_flags[6:0] & r_int_enable[6:0];
                n_int_flags[FLAG_SUMMARY] = |pending;
                n_t2_previous = t2_next;
            end
            CMD_READ: begin
                unique case (t_reg_addr'(i_item.reg_addr))
                    REG_ORB:  read_data = r_port_b;
                    REG_ORA:  read_data = r_port_a;
                    REG_DDRB: read_data = r_dir_b;
                    REG_DDRA: read_data = r_dir_a;
                    REG_T1CL: begin
                        read_data = r_t1_count[7:0];
                        n_int_flags[FLAG_T1] = 1'b0;
                    end
                    REG_T1CH: read_data = r_t1_count[15:8];
                    REG_T1LL: read_data = r_t1_latch[7:0];
                    REG_T1LH: read_data = r_t1_latch[15:8];
                    REG_T2CL: begin
                        read_data = r_t2_count[7:0];
                        n_int_flags[FLAG_T2] = 1'b0;
                    end
                    REG_T2CH: read_data = r_t2_count[15:8];
                    REG_SR:   read_data = r_shift_reg;
                    REG_ACR:  read_data = r_aux_ctrl;
                    REG_PCR:  read_data = r_periph_ctrl;
                    REG_IFR:  read_data = r_int_flags;
                    REG_IER:  read_data = r_int_enable | 8'h80;
                    default:  read_data = r_port_a;
                endcase
            end
            CMD_WRITE: begin
                unique case (t_reg_addr'(i_item.reg_addr))
                    REG_ORB:  n_port_b = i_item.write_data & r_dir_b;
                    REG_ORA:  n_port_a = i_item.write_data & r_dir_a;
                    REG_DDRB: n_dir_b = i_item.write_data;
                    REG_DDRA: n_dir_a = i_item.write_data;
                    REG_T1CL, REG_T1LL: n_t1_latch[7:0] = i_item.write_data;
                    REG_T1CH: begin
                        n_t1_latch[15:8] = i_item.write_data;
                        n_t1_count = {i_item.write_data, r_t1_latch[7:0]};
                        n_int_flags[FLAG_T1] = 1'b0;
                        if (r_aux_ctrl[ACR_PB7_OUT]) begin
                            n_port_b[7] = 1'b0;
                        end
                    end
                    REG_T1LH: begin
                        n_t1_latch[15:8] = i_item.write_data;
                        n_int_flags[FLAG_T1] = 1'b0;
                    end
                    REG_T2CL: n_t2_low_latch = i_item.write_data;
                    REG_T2CH: begin
                        n_t2_count = {i_item.write_data, r_t2_low_latch};
                        n_int_flags[FLAG_T2] = 1'b0;
                    end
                    REG_SR:  n_shift_reg = i_item.write_data;
                    REG_ACR: n_aux_ctrl = i_item.write_data;
                    REG_PCR: n_periph_ctrl = i_item.write_data;
                    REG_IFR: n_int_flags = r_int_flags & (~i_item.write_data | 8'h80);
                    REG_IER: begin
                        if (i_item.write_data[7]) begin
                            n_int_enable = r_int_enable | i_item.write_data | 8'h80;
                        end else begin
                            n_int_enable = r_int_enable & (~i_item.write_data | 8'h80);
                        end
                    end
                    default: n_port_a = i_item.write_data;
                endcase
            end
            CMD_LINES: begin
                if (!i_item.side) begin
                    if (r_periph_ctrl[PCR_CA1_RISE] ? rise : fall) begin
                        n_int_flags[FLAG_CA1] = 1'b1;
                    end
                    n_ca_lines = {i_item.line_two, i_item.line_one};
                end else begin
                    // cb1 clocks cb2 into the shift register
                    if ((r_aux_ctrl & ACR_SR_MASK) == ACR_SR_EXT_IN && rise) begin
                        n_shift_reg = {r_shift_reg[6:0], i_item.line_two};
                        n_shift_count = r_shift_count + 3'd1;
                        if (r_shift_count == SHIFT_LAST) begin
                            n_int_flags[FLAG_SHIFT] = 1'b1;
                        end
                    end
                    if (r_periph_ctrl[PCR_CB1_RISE] ? rise : fall) begin
                        n_int_flags[FLAG_CB1] = 1'b1;
                    end
                    n_cb_lines = {i_item.line_two, i_item.line_one};
                end
            end
            CMD_PINS: begin
                if (!i_item.side) begin
                    n_port_a = i_item.pin_level ? (r_port_a | pin_m) : (r_port_a & ~pin_m);
                end else begin
                    n_port_b = i_item.pin_level ? (r_port_b | pin_m) : (r_port_b & ~pin_m);
                end
            end
            default: ;
        endcase
    end

    assign o_result.read_data  = read_data;
    assign o_result.irq        = n_int_flags[FLAG_SUMMARY];
    assign o_result.port_a_out = n_port_a;
    assign o_result.port_b_out = n_port_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a       <= '0;
            r_port_b       <= '0;
            r_dir_a        <= '0;
            r_dir_b        <= '0;
            r_t1_count     <= '0;
            r_t1_latch     <= '0;
            r_t2_count     <= '0;
            r_t2_previous  <= '0;
            r_t2_low_latch <= '0;
            r_shift_reg    <= '0;
            r_shift_count  <= '0;
            r_aux_ctrl     <= '0;
            r_periph_ctrl  <= '0;
            r_int_flags    <= '0;
            r_int_enable   <= '0;
            r_ca_lines     <= '0;
            r_cb_lines     <= '0;
        end else if (i_step) begin
            r_port_a       <= n_port_a;
            r_port_b       <= n_port_b;
            r_dir_a        <= n_dir_a;
            r_dir_b        <= n_dir_b;
            r_t1_count     <= n_t1_count;
            r_t1_latch     <= n_t1_latch;
            r_t2_count     <= n_t2_count;
            r_t2_previous  <= n_t2_previous;
            r_t2_low_latch <= n_t2_low_latch;
            r_shift_reg    <= n_shift_reg;
            r_shift_count  <= n_shift_count;
            r_aux_ctrl     <= n_aux_ctrl;
            r_periph_ctrl  <= n_periph_ctrl;
            r_int_flags    <= n_int_flags;
            r_int_enable   <= n_int_enable;
            r_ca_lines     <= n_ca_lines;
            r_cb_lines     <= n_cb_lines;
        end
    end

endmodule
